### rtl/gf2m_element_min_poly_top_defines.svh
`ifndef GF2M_ELEMENT_MIN_POLY_TOP_DEFINES_SVH
`define GF2M_ELEMENT_MIN_POLY_TOP_DEFINES_SVH

// Check that holds in the same cycle once the antecedent is true.
`define GEMP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Check that holds in the cycle after the antecedent.
`define GEMP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gemp_pkg.sv
package gemp_pkg;

   localparam int MaxDegree = 16;
   localparam int NumSlots  = MaxDegree + 1;
   localparam int ElemW     = 16;
   localparam int ModW      = 17;
   localparam int DegW      = 5;
   localparam int SlotW     = $clog2(NumSlots);
   localparam int ProdW     = 2 * ElemW - 1;

   typedef struct packed {
      logic [ElemW-1:0] element;
      logic             want_minimal;
   } req_type;

   typedef struct packed {
      logic [ModW-1:0] poly_bits;
      logic [DegW-1:0] poly_degree;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_SQUARE,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic            load;
      logic            mac;
      logic            square;
      logic            publish;
      logic            invalid;
      logic [DegW-1:0] degree;
   } cmd_type;

   typedef struct packed {
      logic [DegW-1:0] deg;
      logic            invalid;
      logic            ap_eq_a;
   } status_type;

   // Carry-less product of a and b, reduced modulo m of degree d.
   function automatic logic [ElemW-1:0] gf_mul(input logic [ElemW-1:0] a,
                                               input logic [ElemW-1:0] b,
                                               input logic [ModW-1:0]  m,
                                               input logic [DegW-1:0]  d);
      logic [ProdW-1:0] p;
      logic [ProdW-1:0] mx;
      p  = '0;
      mx = ProdW'(m);
      for (int i = 0; i < ElemW; i++) begin
         if (b[i]) begin
            p = p ^ (ProdW'(a) << i);
         end
      end
      for (int i = ProdW - 1; i >= 1; i--) begin
         if (i >= int'(d) && p[i]) begin
            p = p ^ (mx << (i - int'(d)));
         end
      end
      return p[ElemW-1:0];
   endfunction

endpackage

### rtl/gemp_dpath.sv
module gemp_dpath
   import gemp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [ModW-1:0] csr_wdata,
   input  req_type         req,
   input  cmd_type         cmd,
   output status_type      status,
   output logic            rsp_valid,
   output rsp_type         rsp
);

   logic [ModW-1:0]  modulus_ff;
   logic [ElemW-1:0] a_ff, ap_ff, carry_ff;
   logic [ElemW-1:0] coef_ff [NumSlots];
   logic [ElemW-1:0] mul_a, mul_b, mul_out;
   logic [DegW-1:0]  deg;
   logic [ModW-1:0]  bits;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   always_comb begin
      deg = '0;
      for (int i = 0; i < ModW; i++) begin
         if (modulus_ff[i]) begin
            deg = DegW'(i);
         end
      end
   end

   assign status.deg     = deg;
   assign status.invalid = (modulus_ff[ModW-1:1] == '0);
   assign status.ap_eq_a = (ap_ff == a_ff);

   // The one shared multiplier: reduction on load, ring update, squaring.
   always_comb begin
      if (cmd.load) begin
         mul_a = req.element;
         mul_b = ElemW'(1);
      end else if (cmd.square) begin
         mul_a = ap_ff;
         mul_b = ap_ff;
      end else begin
         mul_a = ap_ff;
         mul_b = coef_ff[0];
      end
   end

   assign mul_out = gf_mul(mul_a, mul_b, modulus_ff, deg);

   always_comb begin
      for (int j = 0; j < NumSlots; j++) begin
         bits[j] = coef_ff[j][0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= ModW'(7);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
         rsp_valid_ff <= cmd.publish;
      end
   end

   // The coefficients circulate through a ring; one full turn multiplies
   // the polynomial by (x + ap), the carry holding the lower old coefficient.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff     <= mul_out;
         ap_ff    <= mul_out;
         carry_ff <= '0;
         for (int j = 0; j < NumSlots; j++) begin
            coef_ff[j] <= (j == 0) ? ElemW'(1) : '0;
         end
      end else if (cmd.mac) begin
         carry_ff <= coef_ff[0];
         for (int j = 0; j < NumSlots - 1; j++) begin
            coef_ff[j] <= coef_ff[j+1];
         end
         coef_ff[NumSlots-1] <= carry_ff ^ mul_out;
      end else if (cmd.square) begin
         ap_ff    <= mul_out;
         carry_ff <= '0;
      end
      if (cmd.publish) begin
         rsp_ff.poly_bits   <= cmd.invalid ? ModW'(1) : bits;
         rsp_ff.poly_degree <= cmd.invalid ? '0 : cmd.degree;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/gemp_ctrl.sv
`include "gf2m_element_min_poly_top_defines.svh"

module gemp_ctrl
   import gemp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       want_minimal,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [DegW-1:0]  k_ff, k_in;
   logic             min_ff, min_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         k_ff     <= '0;
         min_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         k_ff     <= k_in;
         min_ff   <= min_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      k_in     = k_ff;
      min_in   = min_ff;
      cmd      = '0;
      cmd.degree = k_ff;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.invalid) begin
                  cmd.publish = 1'b1;
                  cmd.invalid = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  min_in   = want_minimal;
                  k_in     = '0;
                  slot_in  = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.mac = 1'b1;
            if (slot_ff == SlotW'(NumSlots - 1)) begin
               slot_in  = '0;
               state_in = ST_SQUARE;
            end else begin
               slot_in = slot_ff + SlotW'(1);
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            k_in       = k_ff + DegW'(1);
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (k_ff == status.deg || (min_ff && status.ap_eq_a)) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_MAC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `GEMP_ASSERT_NOW(a_k_bound, 1'b1, k_ff <= DegW'(MaxDegree), "factor count above maximum")
   `GEMP_ASSERT_NOW(a_slot_idle, state_ff != ST_MAC, slot_ff == '0, "slot count outside ring turn")
   `GEMP_ASSERT_NEXT(a_pub_idle, cmd.publish, state_ff == ST_IDLE, "no return to idle after result")

endmodule

### rtl/gf2m_element_min_poly_top.sv
// Minimal or characteristic polynomial of an element of GF(2^d), the field
// set by the modulus written through csr_wdata. An item is taken when start
// is high and busy is low; its result shows on rsp for one cycle with
// rsp_valid high and must be taken then, since the receiver cannot stall.
// An item with k factors takes k rounds: each factor costs a full turn of
// the coefficient ring through the single field multiplier plus a squaring
// state and a check state, and busy stays high until the result is published.
// A modulus of degree zero returns its result in the cycle after the item,
// with busy never raised.
module gf2m_element_min_poly_top
   import gemp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req,
   output logic            rsp_valid,
   output rsp_type         rsp,
   input  logic            csr_we,
   input  logic [ModW-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   gemp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .want_minimal (req.want_minimal),
      .status       (status),
      .busy         (busy),
      .cmd          (cmd)
   );

   gemp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

### bench/gf2m_element_min_poly_checker.sv
module gf2m_element_min_poly_checker
   import gemp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            busy,
   input  req_type         req,
   input  logic            rsp_valid,
   input  rsp_type         rsp,
   input  logic            csr_we,
   input  logic [ModW-1:0] csr_wdata,
   output int              failures,
   output int              outstanding,
   output int              polys_checked
);

   logic [ModW-1:0] modulus_copy;
   rsp_type         poly_queue[$];

   function automatic int degree_of(logic [31:0] p);
      int d;
      d = -1;
      for (int i = 0; i < 32; i++) begin
         if (p[i]) begin
            d = i;
         end
      end
      return d;
   endfunction

   function automatic logic [31:0] field_mul(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] m, int d);
      logic [31:0] acc;
      acc = '0;
      for (int i = d - 1; i >= 0; i--) begin
         acc = acc << 1;
         if (acc[d]) begin
            acc = acc ^ m;
         end
         if (b[i]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   // Multiplies out the Frobenius conjugate factors of the element.
   function automatic rsp_type conjugate_product(logic [ModW-1:0] mod, req_type r);
      rsp_type     res;
      logic [31:0] m;
      logic [31:0] a;
      logic [31:0] ap;
      logic [31:0] coef[34];
      logic [16:0] bits;
      int          d;
      int          k;
      m = 32'(mod);
      d = degree_of(m);
      if (d < 1 || d > MaxDegree) begin
         res.poly_bits   = 17'd1;
         res.poly_degree = '0;
         return res;
      end
      a = 32'(r.element);
      for (int i = 31; i >= d; i--) begin
         if (a[i]) begin
            a = a ^ (m << (i - d));
         end
      end
      foreach (coef[j]) coef[j] = '0;
      coef[0] = 32'd1;
      k = 0;
      ap = a;
      for (int i = 0; i < d; i++) begin
         for (int j = k + 1; j >= 1; j--) begin
            coef[j] = coef[j-1] ^ field_mul(ap, coef[j], m, d);
         end
         coef[0] = field_mul(ap, coef[0], m, d);
         k++;
         ap = field_mul(ap, ap, m, d);
         if (r.want_minimal && ap == a) begin
            break;
         end
      end
      bits = '0;
      for (int j = 0; j <= k; j++) begin
         bits[j] = coef[j][0];
      end
      res.poly_bits   = bits;
      res.poly_degree = DegW'(k);
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      failures++;
   endtask

   initial begin
      failures      = 0;
      polys_checked = 0;
      outstanding   = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         modulus_copy = 17'd7;
         poly_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (poly_queue.size() == 0) begin
               report_mismatch($sformatf("result %h with no item waiting", rsp));
            end else begin
               want = poly_queue.pop_front();
               polys_checked++;
               if (rsp.poly_bits !== want.poly_bits) begin
                  report_mismatch($sformatf("poly_bits %h, expected %h",
                                            rsp.poly_bits, want.poly_bits));
               end
               if (rsp.poly_degree !== want.poly_degree) begin
                  report_mismatch($sformatf("poly_degree %0d, expected %0d",
                                            rsp.poly_degree, want.poly_degree));
               end
            end
         end
         if (start && !busy) begin
            poly_queue.push_back(conjugate_product(modulus_copy, req));
         end
         if (csr_we) begin
            modulus_copy = csr_wdata;
         end
      end
      outstanding = poly_queue.size();
   end

   final begin
      if (poly_queue.size() != 0) begin
         $display("%0d results never arrived", poly_queue.size());
      end
   end

endmodule

### bench/tb.sv
module tb;
   import gemp_pkg::*;

   localparam int DrainCycles = 330;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_type         req;
   logic            rsp_valid;
   rsp_type         rsp;
   logic            csr_we;
   logic [ModW-1:0] csr_wdata;
   int              failures;
   int              outstanding;
   int              polys_checked;
   int              idle_pct;
   int              items_sent;

   gf2m_element_min_poly_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   gf2m_element_min_poly_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .failures(failures), .outstanding(outstanding), .polys_checked(polys_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(4 * 2_000_000);
      $display("tb NOT OK");
      $finish;
   end

   // Start stays high from one item to the next unless a gap is drawn.
   // Busy only changes at the rising edge, so it is stable at the falling one.
   task automatic send_item(logic [ElemW-1:0] element, logic want_minimal);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req.element      <= element;
      req.want_minimal <= want_minimal;
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   // The block may still be finishing a result once the queue is empty.
   task automatic write_modulus(logic [ModW-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [ModW-1:0] modulus, int count, int pct);
      write_modulus(modulus);
      idle_pct = pct;
      send_item(16'h0000, 1'b0);
      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b1);
      send_item(16'h0001, 1'b1);
      send_item(16'h0002, 1'b1);
      for (int i = 0; i < count; i++) begin
         if (i % 30 < 6) begin
            idle_pct = 0;
         end else begin
            idle_pct = pct;
         end
         // Mostly reduced elements, sometimes full-width unreduced ones.
         if ($urandom_range(3) == 0) begin
            send_item(16'($urandom), 1'($urandom));
         end else begin
            send_item(16'($urandom & (modulus >> 1)), 1'($urandom));
         end
      end
   endtask

   initial begin
      start      = 1'b0;
      req        = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      items_sent = 0;
      idle_pct   = 0;
      reset      = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_phase(17'h00007, 80, 0);
      run_phase(17'h00013, 100, 48);
      run_phase(17'h00000, 30, 11);
      run_phase(17'h00001, 30, 48);
      run_phase(17'h00002, 30, 0);
      run_phase(17'h00003, 30, 11);
      run_phase(17'h0011D, 150, 0);
      run_phase(17'h00011, 80, 48);
      run_phase(17'h00025, 120, 11);
      run_phase(17'h1100B, 60, 0);
      run_phase(17'h1FFFF, 40, 48);
      run_phase(17'(17'h100 | $urandom_range(255)), 100, 11);
      run_phase(17'h00007, 60, 48);

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d items sent over 13 modulus settings (degrees 0 to 16),",
               items_sent);
      $display("%0d result polynomials checked, both modes, with and without gaps.",
               polys_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/gemp_pkg.sv
rtl/gemp_dpath.sv
rtl/gemp_ctrl.sv
rtl/gf2m_element_min_poly_top.sv
bench/gf2m_element_min_poly_checker.sv
bench/tb.sv
